[rtl/core/pvsp_pkg.sv]
// ----------------------------------------------------------------------------
// pvsp_pkg - shared types and constants of the pulse-vector stepper positioner
// Request codes, sequencer states, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pvsp_pkg;

	// Word field widths
	localparam int REQ_W       = 3;
	localparam int BYTE_W      = 8;
	localparam int STEP_CNT_W  = 8;
	localparam int ANGLE_W     = 9;
	localparam int WIN_W       = 16;
	localparam int DELAY_W     = 5;
	localparam int MODE_W      = 3;

	// Settings after reset
	localparam logic [DELAY_W-1:0] DELAY_RESET = 5'd20;
	localparam logic [MODE_W-1:0]  MODE_RESET  = 3'd2;

	// Request codes carried in req_type
	typedef enum logic [REQ_W-1:0] {
		REQ_X_PULSE = 3'd0,
		REQ_Y_PULSE = 3'd1,
		REQ_TICK    = 3'd2,
		REQ_JOG     = 3'd3,
		REQ_SERIAL  = 3'd4
	} req_t;

	// Top-level sequencer
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ROOT,
		SEQ_MOVE
	} seq_state_t;

	// Root unit phases
	typedef enum logic [2:0] {
		RU_IDLE,
		RU_SQ_X,
		RU_SQ_Y,
		RU_SUM,
		RU_ROOT
	} ru_phase_t;

	// Root unit status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} ru_status_t;

endpackage

`default_nettype wire

[rtl/core/pvsp_channels.sv]
// ----------------------------------------------------------------------------
// pvsp_channels - valid/ready channels of the stepper positioner
// Event words in, move report words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvsp_evt_if;
	logic                            valid;
	logic                            ready;
	logic [pvsp_pkg::REQ_W-1:0]      req_type;
	logic                            pulse_up;
	logic                            jog_clockwise;
	logic [pvsp_pkg::BYTE_W-1:0]     rx_byte;
	logic                            rx_ninth_bit;

	modport source (
		output valid, req_type, pulse_up, jog_clockwise, rx_byte, rx_ninth_bit,
		input  ready
	);
	modport sink (
		input  valid, req_type, pulse_up, jog_clockwise, rx_byte, rx_ninth_bit,
		output ready
	);
endinterface

interface pvsp_move_if;
	logic                               valid;
	logic                               ready;
	logic                               step_clockwise;
	logic [pvsp_pkg::STEP_CNT_W-1:0]    step_count;
	logic [pvsp_pkg::ANGLE_W-1:0]       angle;
	logic signed [pvsp_pkg::WIN_W-1:0]  x_count;
	logic signed [pvsp_pkg::WIN_W-1:0]  y_count;
	logic [pvsp_pkg::DELAY_W-1:0]       step_delay;
	logic [pvsp_pkg::MODE_W-1:0]        report_mode;

	modport source (
		output valid, step_clockwise, step_count, angle, x_count, y_count,
		       step_delay, report_mode,
		input  ready
	);
	modport sink (
		input  valid, step_clockwise, step_count, angle, x_count, y_count,
		       step_delay, report_mode,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/pvsp_root_unit.sv]
// ----------------------------------------------------------------------------
// pvsp_root_unit - vector length to angle
// Squares both window counts on one multiplier, sums them, then extracts the
// floor square root one bit a cycle while reducing it modulo the turn length.
// ----------------------------------------------------------------------------
`default_nettype none

module pvsp_root_unit #(
	parameter int COUNT_BITS     = 16,
	parameter int STEPS_PER_TURN = 400,
	localparam int AW            = $clog2(STEPS_PER_TURN)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [COUNT_BITS-1:0] x_win,
	input  wire logic signed [COUNT_BITS-1:0] y_win,
	output pvsp_pkg::ru_status_t              status,
	output logic [AW-1:0]                     target
);

	localparam int SUM_W = 2 * COUNT_BITS;
	localparam int REM_W = COUNT_BITS + 1;
	localparam int CNT_W = $clog2(COUNT_BITS);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(COUNT_BITS - 1);
	localparam logic [AW:0]      MOD_K    = (AW + 1)'(STEPS_PER_TURN);

	pvsp_pkg::ru_phase_t phase_q, phase_d;

	logic [CNT_W-1:0]      cnt_q;
	logic [SUM_W-1:0]      prod_q;
	logic [SUM_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [COUNT_BITS-1:0] root_q;
	logic [AW-1:0]         mod_q;
	logic                  done_q;

	logic signed [COUNT_BITS-1:0] mul_src;
	logic [COUNT_BITS-1:0]        mag;
	logic [SUM_W-1:0]             prod;
	logic [COUNT_BITS+1:0]        rem4;
	logic [COUNT_BITS+1:0]        trial;
	logic [COUNT_BITS+1:0]        rem_nx;
	logic                         take;
	logic [AW:0]                  mod2;
	logic [AW:0]                  mod_nx;

	// Square the selected count on the shared multiplier
	always_comb begin
		mul_src = (phase_q == pvsp_pkg::RU_SQ_X) ? x_win : y_win;
		mag     = mul_src[COUNT_BITS-1] ? (~mul_src + 1'b1) : mul_src;
		prod    = SUM_W'(mag) * SUM_W'(mag);
	end

	// One root bit: compare remainder with trial, fold the bit into the modulus
	always_comb begin
		rem4   = {rem_q[COUNT_BITS-1:0], rad_q[SUM_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = (rem4 >= trial);
		rem_nx = take ? (rem4 - trial) : rem4;
		mod2   = {mod_q, take};
		mod_nx = (mod2 >= MOD_K) ? (mod2 - MOD_K) : mod2;
	end

	// Phase sequencing
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			pvsp_pkg::RU_IDLE: begin
				if (start) phase_d = pvsp_pkg::RU_SQ_X;
			end
			pvsp_pkg::RU_SQ_X: phase_d = pvsp_pkg::RU_SQ_Y;
			pvsp_pkg::RU_SQ_Y: phase_d = pvsp_pkg::RU_SUM;
			pvsp_pkg::RU_SUM:  phase_d = pvsp_pkg::RU_ROOT;
			pvsp_pkg::RU_ROOT: begin
				if (cnt_q == '0) phase_d = pvsp_pkg::RU_IDLE;
			end
			default: phase_d = pvsp_pkg::RU_IDLE;
		endcase
	end

	// Status toward the sequencer
	always_comb begin
		status.busy = (phase_q != pvsp_pkg::RU_IDLE);
		status.done = done_q;
		target      = mod_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pvsp_pkg::RU_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == pvsp_pkg::RU_ROOT) && (cnt_q == '0);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (phase_q)
			pvsp_pkg::RU_SQ_X: begin
				prod_q <= prod;
			end
			pvsp_pkg::RU_SQ_Y: begin
				rad_q  <= prod_q;
				prod_q <= prod;
			end
			pvsp_pkg::RU_SUM: begin
				rad_q  <= rad_q + prod_q;
				rem_q  <= '0;
				root_q <= '0;
				mod_q  <= '0;
				cnt_q  <= LAST_BIT;
			end
			pvsp_pkg::RU_ROOT: begin
				rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
				rem_q  <= rem_nx[REM_W-1:0];
				root_q <= {root_q[COUNT_BITS-2:0], take};
				mod_q  <= mod_nx[AW-1:0];
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/pulse_vector_stepper_positioner.sv]
// ----------------------------------------------------------------------------
// pulse_vector_stepper_positioner - pulse counting stepper positioner
// Counts X/Y pulses, and at each window end turns the vector length into a
// shortest move on the step circle; jogs move one step; serial bytes set
// the step delay and report mode.
//
//   channel | dir | word
//   --------+-----+------------------------------------------------------
//   evt     | in  | req_type, pulse_up, jog_clockwise, rx_byte, rx_ninth_bit
//   move    | out | step_clockwise, step_count, angle, x_count, y_count,
//           |     | step_delay, report_mode
//
// Pulses, serial bytes and ticks inside a window keep evt ready. A jog
// holds events off through the move state; a window-end tick holds them off
// through the bit-serial square root in the root unit and the move state.
// The move word sits in an output register; new events are taken while it
// waits, but a move is held back until the register is free.
// Reset: accumulators, window and angle clear, delay 20, report mode 2.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_vector_stepper_positioner #(
	parameter int STEPS_PER_TURN = 400,
	parameter int WINDOW_TICKS   = 30,
	parameter int COUNT_BITS     = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pvsp_evt_if.sink   evt,
	pvsp_move_if.source move
);

	localparam int AW   = $clog2(STEPS_PER_TURN);
	localparam int TW   = $clog2(WINDOW_TICKS + 1);
	localparam int DW   = AW + 2;
	localparam int HALF = STEPS_PER_TURN / 2;
	localparam logic signed [DW-1:0]         HALF_S  = DW'(HALF);
	localparam logic signed [DW-1:0]         TURN_S  = DW'(STEPS_PER_TURN);
	localparam logic [AW-1:0]                ANG_TOP = AW'(STEPS_PER_TURN - 1);
	localparam logic [TW-1:0]                TICK_END = TW'(WINDOW_TICKS - 1);
	localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

	pvsp_pkg::seq_state_t state_q, state_d;
	pvsp_pkg::ru_status_t ru_status;

	logic signed [COUNT_BITS-1:0] x_acc_q, y_acc_q, x_win_q, y_win_q;
	logic [TW-1:0]                tick_q;
	logic [AW-1:0]                angle_q;
	logic [pvsp_pkg::DELAY_W-1:0] delay_q;
	logic [pvsp_pkg::MODE_W-1:0]  mode_q;
	logic                         jog_q, jog_cw_q;

	logic                                out_vld_q;
	logic                                out_cw_q;
	logic [pvsp_pkg::STEP_CNT_W-1:0]     out_cnt_q;
	logic [pvsp_pkg::ANGLE_W-1:0]        out_angle_q;
	logic signed [pvsp_pkg::WIN_W-1:0]   out_x_q, out_y_q;
	logic [pvsp_pkg::DELAY_W-1:0]        out_delay_q;
	logic [pvsp_pkg::MODE_W-1:0]         out_mode_q;

	logic          accept, tick_last, window_end, parity_ok, slot_free, load_out;
	logic [AW-1:0] target;
	logic signed [DW-1:0] diff_raw, diff_w, diff_mag;
	logic          move_cw;
	logic [DW-1:0] move_cnt;
	logic [AW-1:0] angle_up, angle_dn, next_angle;

	// Event decode
	always_comb begin
		accept     = evt.valid && evt.ready;
		tick_last  = (tick_q == TICK_END);
		window_end = accept && (evt.req_type == pvsp_pkg::REQ_TICK) && tick_last;
		parity_ok  = ((^evt.rx_byte) == evt.rx_ninth_bit);
		slot_free  = !out_vld_q || move.ready;
	end

	pvsp_root_unit #(
		.COUNT_BITS     (COUNT_BITS),
		.STEPS_PER_TURN (STEPS_PER_TURN)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (window_end),
		.x_win  (x_win_q),
		.y_win  (y_win_q),
		.status (ru_status),
		.target (target)
	);

	// Shortest move toward the target, or one jog step
	always_comb begin
		diff_raw = $signed({2'b00, target}) - $signed({2'b00, angle_q});
		if (diff_raw > HALF_S) begin
			diff_w = diff_raw - TURN_S;
		end else if (diff_raw < -HALF_S) begin
			diff_w = diff_raw + TURN_S;
		end else begin
			diff_w = diff_raw;
		end
		diff_mag = diff_w[DW-1] ? -diff_w : diff_w;
		angle_up = (angle_q == ANG_TOP) ? '0 : angle_q + 1'b1;
		angle_dn = (angle_q == '0) ? ANG_TOP : angle_q - 1'b1;
		if (jog_q) begin
			move_cw    = jog_cw_q;
			move_cnt   = DW'(1);
			next_angle = jog_cw_q ? angle_up : angle_dn;
		end else begin
			move_cw    = (diff_w > 0);
			move_cnt   = diff_mag;
			next_angle = target;
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pvsp_pkg::SEQ_IDLE: begin
				if (window_end) begin
					state_d = pvsp_pkg::SEQ_ROOT;
				end else if (accept && (evt.req_type == pvsp_pkg::REQ_JOG)) begin
					state_d = pvsp_pkg::SEQ_MOVE;
				end
			end
			pvsp_pkg::SEQ_ROOT: begin
				if (ru_status.done) state_d = pvsp_pkg::SEQ_MOVE;
			end
			pvsp_pkg::SEQ_MOVE: begin
				if (slot_free) state_d = pvsp_pkg::SEQ_IDLE;
			end
			default: state_d = pvsp_pkg::SEQ_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		evt.ready = (state_q == pvsp_pkg::SEQ_IDLE);
		load_out  = (state_q == pvsp_pkg::SEQ_MOVE) && slot_free;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pvsp_pkg::SEQ_IDLE;
			x_acc_q   <= '0;
			y_acc_q   <= '0;
			x_win_q   <= '0;
			y_win_q   <= '0;
			tick_q    <= '0;
			angle_q   <= '0;
			delay_q   <= pvsp_pkg::DELAY_RESET;
			mode_q    <= pvsp_pkg::MODE_RESET;
			jog_q     <= 1'b0;
			jog_cw_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (evt.req_type)
					pvsp_pkg::REQ_X_PULSE: begin
						if (evt.pulse_up && (x_acc_q != CMAX)) x_acc_q <= x_acc_q + 1'b1;
						else if (!evt.pulse_up && (x_acc_q != CMIN)) x_acc_q <= x_acc_q - 1'b1;
					end
					pvsp_pkg::REQ_Y_PULSE: begin
						if (evt.pulse_up && (y_acc_q != CMAX)) y_acc_q <= y_acc_q + 1'b1;
						else if (!evt.pulse_up && (y_acc_q != CMIN)) y_acc_q <= y_acc_q - 1'b1;
					end
					pvsp_pkg::REQ_TICK: begin
						// close the window: capture and clear the counts
						if (tick_last) begin
							tick_q  <= '0;
							x_win_q <= x_acc_q;
							y_win_q <= y_acc_q;
							x_acc_q <= '0;
							y_acc_q <= '0;
							jog_q   <= 1'b0;
						end else begin
							tick_q <= tick_q + 1'b1;
						end
					end
					pvsp_pkg::REQ_JOG: begin
						jog_q    <= 1'b1;
						jog_cw_q <= evt.jog_clockwise;
					end
					pvsp_pkg::REQ_SERIAL: begin
						if (parity_ok) begin
							delay_q <= evt.rx_byte[pvsp_pkg::DELAY_W-1:0];
							mode_q  <= evt.rx_byte[pvsp_pkg::BYTE_W-1 -: pvsp_pkg::MODE_W];
						end
					end
					default: begin
					end
				endcase
			end
			if (load_out) begin
				angle_q   <= next_angle;
				out_vld_q <= 1'b1;
			end else if (move.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Move word register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cw_q    <= move_cw;
			out_cnt_q   <= pvsp_pkg::STEP_CNT_W'(move_cnt);
			out_angle_q <= pvsp_pkg::ANGLE_W'(next_angle);
			out_x_q     <= pvsp_pkg::WIN_W'(x_win_q);
			out_y_q     <= pvsp_pkg::WIN_W'(y_win_q);
			out_delay_q <= delay_q;
			out_mode_q  <= mode_q;
		end
	end

	assign move.valid          = out_vld_q;
	assign move.step_clockwise = out_cw_q;
	assign move.step_count     = out_cnt_q;
	assign move.angle          = out_angle_q;
	assign move.x_count        = out_x_q;
	assign move.y_count        = out_y_q;
	assign move.step_delay     = out_delay_q;
	assign move.report_mode    = out_mode_q;

endmodule

`default_nettype wire

[rtl/core/pvsp_checker.sv]
// ----------------------------------------------------------------------------
// pvsp_checker - port-level checks of the stepper positioner
// Watches the move channel for held words and legal move reports.
// ----------------------------------------------------------------------------
`default_nettype none

module pvsp_checker #(
	parameter int STEPS_PER_TURN = 400
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic                              step_clockwise,
	input wire logic [pvsp_pkg::STEP_CNT_W-1:0]   step_count,
	input wire logic [pvsp_pkg::ANGLE_W-1:0]      angle
);

	localparam int HALF = STEPS_PER_TURN / 2;
	localparam bit ANGLE_WIDE = (STEPS_PER_TURN > 512);
	localparam bit COUNT_WIDE = (HALF > 255);

	// a stalled move word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(step_count) && $stable(angle)
		&& $stable(step_clockwise))
		else $error("move word changed while stalled");

	// reported angle stays on the circle
	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ANGLE_WIDE || (int'(angle) < STEPS_PER_TURN))
		else $error("angle off the circle");

	// a move never exceeds half a turn
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> COUNT_WIDE || (int'(step_count) <= HALF))
		else $error("move longer than half a turn");

	// a zero move reports anticlockwise
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (step_count == '0) |-> !step_clockwise)
		else $error("zero move marked clockwise");

endmodule

bind pulse_vector_stepper_positioner pvsp_checker #(
	.STEPS_PER_TURN (STEPS_PER_TURN)
) u_pvsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (move.valid),
	.out_ready      (move.ready),
	.step_clockwise (move.step_clockwise),
	.step_count     (move.step_count),
	.angle          (move.angle)
);

`default_nettype wire

[verif/tb_pulse_vector_stepper_positioner.sv]
// ----------------------------------------------------------------------------
// tb_pulse_vector_stepper_positioner - self-checking bench of the positioner
// A directed table (jogs, parity checks, spare codes, window ends with short,
// backward and half-turn moves) is followed by random event mixes under four
// handshake pressure settings. Every accepted event word runs through a
// behavioral predictor; each move word is compared field by field against the
// oldest queued move, predicted or hand-written in the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pulse_vector_stepper_positioner;

	localparam int STEPS        = 400;
	localparam int HALF_TURN    = STEPS / 2;
	localparam int WIN_TICKS    = 30;
	localparam int CNT_BITS     = 16;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_WORDS  = 100;
	localparam int PHASE_MOVES  = 4;

	// Request codes the block must ignore
	localparam logic [pvsp_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [pvsp_pkg::REQ_W-1:0] REQ_SPARE_MD = 3'd6;
	localparam logic [pvsp_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	localparam logic signed [pvsp_pkg::WIN_W-1:0] CNT_MAX = 16'sh7FFF;
	localparam logic signed [pvsp_pkg::WIN_W-1:0] CNT_MIN = 16'sh8000;

	typedef struct packed {
		logic                                cw;
		logic [pvsp_pkg::STEP_CNT_W-1:0]     steps;
		logic [pvsp_pkg::ANGLE_W-1:0]        angle;
		logic signed [pvsp_pkg::WIN_W-1:0]   x;
		logic signed [pvsp_pkg::WIN_W-1:0]   y;
		logic [pvsp_pkg::DELAY_W-1:0]        delay;
		logic [pvsp_pkg::MODE_W-1:0]         mode;
	} move_word_t;

	// Event word plus repeat count and an optional hand-written move
	typedef struct packed {
		logic [pvsp_pkg::REQ_W-1:0]  req;
		logic                        up;
		logic                        jog_cw;
		logic [pvsp_pkg::BYTE_W-1:0] rx;
		logic                        ninth;
		int                          reps;
		logic                        fixed;
		move_word_t                  want;
	} stim_t;

	localparam move_word_t NO_MOVE = '0;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic  evt_valid_q = 1'b0;
	stim_t bus_word    = '0;
	logic  take_q      = 1'b0;

	pvsp_evt_if  evt();
	pvsp_move_if move();

	assign evt.valid         = evt_valid_q;
	assign evt.req_type      = bus_word.req;
	assign evt.pulse_up      = bus_word.up;
	assign evt.jog_clockwise = bus_word.jog_cw;
	assign evt.rx_byte       = bus_word.rx;
	assign evt.rx_ninth_bit  = bus_word.ninth;
	assign move.ready        = take_q;

	pulse_vector_stepper_positioner #(
		.STEPS_PER_TURN(STEPS),
		.WINDOW_TICKS  (WIN_TICKS),
		.COUNT_BITS    (CNT_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt),
		.move  (move)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state
	logic signed [pvsp_pkg::WIN_W-1:0] x_acc     = '0;
	logic signed [pvsp_pkg::WIN_W-1:0] y_acc     = '0;
	logic signed [pvsp_pkg::WIN_W-1:0] x_win     = '0;
	logic signed [pvsp_pkg::WIN_W-1:0] y_win     = '0;
	int                                tick_cnt  = 0;
	int                                shaft     = 0;
	logic [pvsp_pkg::DELAY_W-1:0]      delay_set = pvsp_pkg::DELAY_RESET;
	logic [pvsp_pkg::MODE_W-1:0]       mode_set  = pvsp_pkg::MODE_RESET;

	stim_t      word_q[$];
	move_word_t pending_moves[$];
	int         words_queued    = 0;
	int         words_taken     = 0;
	int         moves_predicted = 0;
	int         mismatch_cnt    = 0;
	int         send_idle_pct   = 0;
	int         stall_pct       = 0;

	stim_t dir_table [22];

	function automatic logic signed [pvsp_pkg::WIN_W-1:0] nudge(
			input logic signed [pvsp_pkg::WIN_W-1:0] v, input logic up);
		if (up) begin
			return (v == CNT_MAX) ? v : v + 16'sd1;
		end
		return (v == CNT_MIN) ? v : v - 16'sd1;
	endfunction

	// Floor of the square root, by bisection over the reachable range
	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= n) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo;
	endfunction

	// Apply one accepted event word and queue the move it causes, if any
	task automatic step_positioner(input stim_t w);
		move_word_t      m;
		longint unsigned ax;
		longint unsigned ay;
		int              target;
		int              diff;
		logic            made;
		made = 1'b0;
		m    = '0;
		case (w.req)
			pvsp_pkg::REQ_X_PULSE: x_acc = nudge(x_acc, w.up);
			pvsp_pkg::REQ_Y_PULSE: y_acc = nudge(y_acc, w.up);
			pvsp_pkg::REQ_TICK: begin
				tick_cnt++;
				if (tick_cnt >= WIN_TICKS) begin
					tick_cnt = 0;
					x_win    = x_acc;
					y_win    = y_acc;
					x_acc    = '0;
					y_acc    = '0;
					ax       = (x_win < 0) ? -longint'(x_win) : longint'(x_win);
					ay       = (y_win < 0) ? -longint'(y_win) : longint'(y_win);
					target   = int'(floor_root(ax * ax + ay * ay) % STEPS);
					diff     = target - shaft;
					// take the short way round
					if (diff > HALF_TURN) begin
						diff -= STEPS;
					end else if (diff < -HALF_TURN) begin
						diff += STEPS;
					end
					shaft   = (shaft + diff + STEPS) % STEPS;
					m.cw    = (diff > 0);
					m.steps = 8'((diff < 0) ? -diff : diff);
					made    = 1'b1;
				end
			end
			pvsp_pkg::REQ_JOG: begin
				shaft   = w.jog_cw ? (shaft + 1) % STEPS : (shaft + STEPS - 1) % STEPS;
				m.cw    = w.jog_cw;
				m.steps = 8'd1;
				made    = 1'b1;
			end
			pvsp_pkg::REQ_SERIAL: begin
				// take the byte only when the ninth bit matches its parity
				if ((^w.rx) == w.ninth) begin
					delay_set = w.rx[4:0];
					mode_set  = w.rx[7:5];
				end
			end
			default: ;
		endcase
		if (made) begin
			m.angle = 9'(shaft);
			m.x     = x_win;
			m.y     = y_win;
			m.delay = delay_set;
			m.mode  = mode_set;
			pending_moves.push_back(w.fixed ? w.want : m);
			moves_predicted++;
		end
	endtask

	function automatic string move_text(input move_word_t m);
		return $sformatf("cw=%0d steps=%0d angle=%0d x=%0d y=%0d delay=%0d mode=%0d",
			m.cw, m.steps, m.angle, m.x, m.y, m.delay, m.mode);
	endfunction

	task automatic check_move(input move_word_t got);
		move_word_t want;
		if (pending_moves.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10) begin
				$display("unexpected move word at %0t: %s", $realtime, move_text(got));
			end
			return;
		end
		want = pending_moves.pop_front();
		if (got.cw !== want.cw || got.steps !== want.steps || got.angle !== want.angle ||
				got.x !== want.x || got.y !== want.y || got.delay !== want.delay ||
				got.mode !== want.mode) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10) begin
				$display("move mismatch at %0t", $realtime);
				$display("  expected %s", move_text(want));
				$display("  actual   %s", move_text(got));
			end
		end
	endtask

	// Drive event words; predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else begin
			if (evt_valid_q && evt.ready) begin
				step_positioner(bus_word);
				words_taken++;
			end
			if (!evt_valid_q || evt.ready) begin
				if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					bus_word    <= word_q.pop_front();
					evt_valid_q <= 1'b1;
				end else begin
					evt_valid_q <= 1'b0;
				end
			end
		end
	end

	// Stall the move channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_q <= 1'b0;
		end else begin
			take_q <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Check each accepted move word
	always @(posedge clk) begin
		if (arst_n && move.valid && move.ready) begin
			check_move(move_word_t'{move.step_clockwise, move.step_count, move.angle,
				move.x_count, move.y_count, move.step_delay, move.report_mode});
		end
	end

	task automatic queue_word(input stim_t w);
		while (word_q.size() >= 4) @(negedge clk);
		word_q.push_back(w);
		words_queued++;
	endtask

	function automatic stim_t any_word(input logic [pvsp_pkg::REQ_W-1:0] req);
		stim_t w;
		w        = '0;
		w.req    = req;
		w.up     = 1'($urandom_range(1));
		w.jog_cw = 1'($urandom_range(1));
		w.rx     = 8'($urandom_range(255));
		w.ninth  = 1'($urandom_range(1));
		w.reps   = 1;
		return w;
	endfunction

	initial begin : stimulus
		int                         send_idle [4];
		int                         stall [4];
		int                         ph;
		int                         pick;
		int                         run_len;
		int                         ph_words;
		int                         ph_moves;
		int                         k;
		stim_t                      w;
		logic [pvsp_pkg::REQ_W-1:0] axis;
		logic                       dir;

		send_idle = '{0, 72, 0, 15};
		stall     = '{0, 0, 72, 15};

		// req, up, jog_cw, rx, ninth, reps, fixed, move
		dir_table = '{
			// jogs across the wrap point, reset settings
			'{pvsp_pkg::REQ_JOG, 1'b0, 1'b1, 8'h00, 1'b0, 1, 1'b1,
				'{1'b1, 8'd1, 9'd1, 16'sd0, 16'sd0, 5'd20, 3'd2}},
			'{pvsp_pkg::REQ_JOG, 1'b0, 1'b0, 8'h00, 1'b0, 1, 1'b1,
				'{1'b0, 8'd1, 9'd0, 16'sd0, 16'sd0, 5'd20, 3'd2}},
			'{pvsp_pkg::REQ_JOG, 1'b1, 1'b0, 8'hFF, 1'b1, 1, 1'b1,
				'{1'b0, 8'd1, 9'd399, 16'sd0, 16'sd0, 5'd20, 3'd2}},
			'{pvsp_pkg::REQ_JOG, 1'b0, 1'b1, 8'h00, 1'b0, 1, 1'b1,
				'{1'b1, 8'd1, 9'd0, 16'sd0, 16'sd0, 5'd20, 3'd2}},
			// good parity all ones, then bad parity all zeros
			'{pvsp_pkg::REQ_SERIAL, 1'b0, 1'b0, 8'hFF, 1'b0, 1, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_SERIAL, 1'b0, 1'b0, 8'h00, 1'b1, 1, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_JOG, 1'b0, 1'b1, 8'h00, 1'b0, 1, 1'b1,
				'{1'b1, 8'd1, 9'd1, 16'sd0, 16'sd0, 5'd31, 3'd7}},
			'{pvsp_pkg::REQ_SERIAL, 1'b1, 1'b1, 8'h00, 1'b0, 1, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_SERIAL, 1'b0, 1'b0, 8'h01, 1'b0, 1, 1'b0, NO_MOVE},
			// spare codes carry a byte that would pass as serial
			'{REQ_SPARE_LO, 1'b1, 1'b1, 8'hFF, 1'b0, 1, 1'b0, NO_MOVE},
			'{REQ_SPARE_MD, 1'b1, 1'b1, 8'hFF, 1'b0, 1, 1'b0, NO_MOVE},
			'{REQ_SPARE_HI, 1'b1, 1'b1, 8'hFF, 1'b0, 1, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_JOG, 1'b0, 1'b0, 8'h00, 1'b0, 1, 1'b1,
				'{1'b0, 8'd1, 9'd0, 16'sd0, 16'sd0, 5'd0, 3'd0}},
			// empty window: zero move
			'{pvsp_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0, WIN_TICKS, 1'b1, NO_MOVE},
			// 3-4-5 vector
			'{pvsp_pkg::REQ_X_PULSE, 1'b1, 1'b0, 8'h00, 1'b0, 3, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_Y_PULSE, 1'b1, 1'b0, 8'h00, 1'b0, 4, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0, WIN_TICKS, 1'b1,
				'{1'b1, 8'd5, 9'd5, 16'sd3, 16'sd4, 5'd0, 3'd0}},
			'{pvsp_pkg::REQ_SERIAL, 1'b0, 1'b0, 8'h5A, 1'b0, 1, 1'b0, NO_MOVE},
			// long way round is shorter backward
			'{pvsp_pkg::REQ_X_PULSE, 1'b0, 1'b0, 8'h00, 1'b0, 250, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0, WIN_TICKS, 1'b1,
				'{1'b0, 8'd155, 9'd250, -16'sd250, 16'sd0, 5'd26, 3'd2}},
			// exactly half a turn
			'{pvsp_pkg::REQ_X_PULSE, 1'b1, 1'b0, 8'h00, 1'b0, 50, 1'b0, NO_MOVE},
			'{pvsp_pkg::REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0, WIN_TICKS, 1'b1,
				'{1'b0, 8'd200, 9'd50, 16'sd50, 16'sd0, 5'd26, 3'd2}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table with no idling
		foreach (dir_table[r]) begin
			for (k = 0; k < dir_table[r].reps; k++) begin
				queue_word(dir_table[r]);
			end
		end

		// Random event mixes, one pressure setting per phase
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_idle[ph];
			stall_pct     = stall[ph];
			ph_words      = 0;
			ph_moves      = moves_predicted;
			while (ph_words < PHASE_WORDS || moves_predicted - ph_moves < PHASE_MOVES) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					// run of pulses on one axis in one direction, now and then a long one
					axis    = $urandom_range(1) ? pvsp_pkg::REQ_Y_PULSE
						: pvsp_pkg::REQ_X_PULSE;
					dir     = 1'($urandom_range(1));
					run_len = ($urandom_range(15) == 0) ? $urandom_range(300, 40)
						: $urandom_range(12, 1);
					for (k = 0; k < run_len; k++) begin
						w    = any_word(axis);
						w.up = dir;
						queue_word(w);
					end
					ph_words += run_len;
				end else if (pick < 65) begin
					run_len = $urandom_range(8, 1);
					for (k = 0; k < run_len; k++) begin
						queue_word(any_word(pvsp_pkg::REQ_TICK));
					end
					ph_words += run_len;
				end else if (pick < 80) begin
					queue_word(any_word(pvsp_pkg::REQ_JOG));
					ph_words++;
				end else if (pick < 93) begin
					w = any_word(pvsp_pkg::REQ_SERIAL);
					queue_word(w);
					if ((^w.rx) == w.ninth) begin
						ph_words++;
					end
				end else begin
					queue_word(any_word(3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO))));
				end
			end
		end

		// Drain: all words taken, all moves seen, then a quiet spell
		while (words_taken != words_queued) @(negedge clk);
		while (pending_moves.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0 && pending_moves.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/core/pvsp_pkg.sv
rtl/core/pvsp_channels.sv
rtl/core/pvsp_root_unit.sv
rtl/core/pulse_vector_stepper_positioner.sv
rtl/core/pvsp_checker.sv
verif/tb_pulse_vector_stepper_positioner.sv
